// ----- src/satl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// satl_pkg: shared types for the set-associative cache tag lookup
// Holds the item structs of both channels, the internal result struct and the
// sequencer state type.
// ----------------------------------------------------------------------------
package satl_pkg;

  typedef struct packed {
    logic [31:0] address;
    logic [1:0]  victim_way;
  } satl_in_t;

  typedef struct packed {
    logic        hit;
    logic [1:0]  way;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
  } satl_out_t;

  // Lookup outcome handed from the sequencer to the output stage.
  typedef struct packed {
    logic       valid;
    logic       hit;
    logic [1:0] way;
  } satl_res_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_DONE
  } satl_state_t;

  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

endpackage

// ----- src/satl_tag_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// satl_tag_ctrl: tag memory and way-by-way lookup sequencer
// Splits the address, walks the ways of one set through a single tag
// comparator and writes the victim way on a miss. Clears the valid bits
// with one pass over the memory after reset.
// ----------------------------------------------------------------------------
module satl_tag_ctrl #(
  parameter int SETS       = 128,
  parameter int WAYS       = 4,
  parameter int LINE_BYTES = 32,
  parameter int ADDR_BITS  = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  satl_pkg::satl_in_t  item,
  output logic                idle,
  output satl_pkg::satl_res_t res,
  input  logic                res_ready
);

  localparam int OFF_BITS = $clog2(LINE_BYTES);
  localparam int SET_BITS = $clog2(SETS);
  localparam int TAG_RAW  = ADDR_BITS - OFF_BITS - SET_BITS;
  localparam int TAG_W    = (TAG_RAW < 1) ? 1 : TAG_RAW;
  localparam int WAY_W    = (WAYS < 2) ? 1 : $clog2(WAYS);
  localparam int ENTRIES  = SETS * WAYS;
  localparam int ENT_W    = $clog2(ENTRIES);

  localparam logic [32:0] AMASK_W = (33'd1 << ADDR_BITS) - 33'd1;
  localparam logic [31:0] AMASK   = AMASK_W[31:0];

  localparam logic [ENT_W-1:0] LAST_ENT = ENT_W'(ENTRIES - 1);
  localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(WAYS - 1);

  // Victim way reduced modulo the way count, one constant per input code.
  localparam logic [WAY_W-1:0] VM0 = WAY_W'(0 % WAYS);
  localparam logic [WAY_W-1:0] VM1 = WAY_W'(1 % WAYS);
  localparam logic [WAY_W-1:0] VM2 = WAY_W'(2 % WAYS);
  localparam logic [WAY_W-1:0] VM3 = WAY_W'(3 % WAYS);

  satl_pkg::satl_state_t state, state_next;

  logic [TAG_W:0]     mem [ENTRIES];
  logic [TAG_W:0]     rd_data;
  logic [ENT_W-1:0]   clr_addr, clr_addr_next;
  logic [WAY_W-1:0]   way_cnt, way_cnt_next;
  logic [ENT_W-1:0]   base;
  logic [TAG_W-1:0]   tag_q;
  logic [WAY_W-1:0]   victim_q;
  logic               hit_q, hit_next;
  logic [WAY_W-1:0]   way_q, way_next;

  logic               we;
  logic [ENT_W-1:0]   waddr;
  logic [TAG_W:0]     wdata;
  logic               rd_en;
  logic [ENT_W-1:0]   rd_addr;

  logic [31:0]        addr_m;
  logic [31:0]        line;
  logic [31:0]        tag_full;
  logic [SET_BITS-1:0] idx;
  logic [WAY_W-1:0]   victim_m;

  assign addr_m   = item.address & AMASK;
  assign line     = addr_m >> OFF_BITS;
  assign idx      = line[SET_BITS-1:0];
  assign tag_full = line >> SET_BITS;

  always_comb begin
    case (item.victim_way)
      2'd0:    victim_m = VM0;
      2'd1:    victim_m = VM1;
      2'd2:    victim_m = VM2;
      default: victim_m = VM3;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= satl_pkg::ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
    end
  end

  always_ff @(posedge clk) begin
    way_cnt <= way_cnt_next;
    hit_q   <= hit_next;
    way_q   <= way_next;
    if (start && (state == satl_pkg::ST_IDLE)) begin
      base     <= ENT_W'(idx * WAYS);
      tag_q    <= tag_full[TAG_W-1:0];
      victim_q <= victim_m;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    way_cnt_next  = way_cnt;
    hit_next      = hit_q;
    way_next      = way_q;
    we            = 1'b0;
    waddr         = clr_addr;
    wdata         = '0;
    rd_en         = 1'b0;
    rd_addr       = base + ENT_W'(way_cnt);
    idle          = 1'b0;
    res.valid     = 1'b0;
    res.hit       = hit_q;
    res.way       = 2'(way_q);
    case (state)
      satl_pkg::ST_CLEAR: begin
        we            = 1'b1;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == LAST_ENT) begin
          state_next = satl_pkg::ST_IDLE;
        end
      end
      satl_pkg::ST_IDLE: begin
        idle = 1'b1;
        if (start) begin
          way_cnt_next = '0;
          state_next   = satl_pkg::ST_READ;
        end
      end
      satl_pkg::ST_READ: begin
        rd_en      = 1'b1;
        state_next = satl_pkg::ST_CMP;
      end
      satl_pkg::ST_CMP: begin
        if (rd_data[TAG_W] && (rd_data[TAG_W-1:0] == tag_q)) begin
          hit_next   = 1'b1;
          way_next   = way_cnt;
          state_next = satl_pkg::ST_DONE;
        end else if (way_cnt == LAST_WAY) begin
          // Last way checked without a match: fill the victim way.
          hit_next   = 1'b0;
          way_next   = victim_q;
          we         = 1'b1;
          waddr      = base + ENT_W'(victim_q);
          wdata      = {1'b1, tag_q};
          state_next = satl_pkg::ST_DONE;
        end else begin
          way_cnt_next = way_cnt + 1'b1;
          state_next   = satl_pkg::ST_READ;
        end
      end
      satl_pkg::ST_DONE: begin
        res.valid = 1'b1;
        if (res_ready) begin
          state_next = satl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = satl_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

// ----- src/set_assoc_cache_tag_lookup_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup_core: set-associative cache tag lookup
// Tag store with externally chosen victim way, saturating hit and miss
// counters and a registered result item.
// ----------------------------------------------------------------------------
// Each item is one byte address. The set is read one way at a time from a
// single-port tag memory and checked by one comparator: each way examined
// takes a read state and a compare state, the lookup stops at the first
// hit, and a miss, which also writes the victim way, ends after the last way.
// After reset the block clears the valid bits with one pass over the memory,
// one entry a cycle, before the first item is accepted. SETS and LINE_BYTES
// must be powers of two. The result item sits in an output register, so a
// new item may be taken while the previous result still waits.

module set_assoc_cache_tag_lookup_core #(
  parameter int SETS       = 128,
  parameter int WAYS       = 4,
  parameter int LINE_BYTES = 32,
  parameter int ADDR_BITS  = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  satl_pkg::satl_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output satl_pkg::satl_out_t out_data
);

  satl_pkg::satl_res_t res;
  logic                idle;
  logic                start;
  logic                res_ready;
  logic                take;
  logic [31:0]         hit_count, hit_count_next;
  logic [31:0]         miss_count, miss_count_next;

  assign in_ready  = idle;
  assign start     = in_valid && idle;
  assign res_ready = !out_valid || out_ready;
  assign take      = res.valid && res_ready;

  satl_tag_ctrl #(
    .SETS       (SETS),
    .WAYS       (WAYS),
    .LINE_BYTES (LINE_BYTES),
    .ADDR_BITS  (ADDR_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (in_data),
    .idle      (idle),
    .res       (res),
    .res_ready (res_ready)
  );

  always_comb begin
    hit_count_next  = hit_count;
    miss_count_next = miss_count;
    if (res.hit) begin
      if (hit_count != satl_pkg::CNT_MAX) begin
        hit_count_next = hit_count + 32'd1;
      end
    end else begin
      if (miss_count != satl_pkg::CNT_MAX) begin
        miss_count_next = miss_count + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hit_count  <= '0;
      miss_count <= '0;
    end else begin
      if (take) begin
        out_valid  <= 1'b1;
        hit_count  <= hit_count_next;
        miss_count <= miss_count_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data.hit        <= res.hit;
      out_data.way        <= res.way;
      out_data.hit_total  <= hit_count_next;
      out_data.miss_total <= miss_count_next;
    end
  end

endmodule

// ----- src/satl_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// satl_checker: port-level checks for the cache tag lookup
// Watches the channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module satl_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input satl_pkg::satl_in_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input satl_pkg::satl_out_t out_data
);

  // A result that is not taken must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // The sequencer is busy for the whole lookup once an item is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again directly after an item");

  // A lookup passes a read and a compare state, so no result is instant.
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared one cycle after the item");

  // The counter of the reported outcome already includes this item.
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.hit && (out_data.hit_total != 32'd0)) ||
                  (!out_data.hit && (out_data.miss_total != 32'd0)))
    else $error("reported outcome not reflected in its counter");

endmodule

bind set_assoc_cache_tag_lookup_core satl_checker u_satl_checker (.*);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: set-associative cache tag lookup
// Sends directed then random address items, predicts each result with a
// model of the tag store and saturating counters, and checks every result
// item field by field, in order. Both channels stall at random, and the
// output is held off for a long stretch to fill the block.
// ----------------------------------------------------------------------------
module testbench;

  localparam int SETS        = 128;
  localparam int WAYS        = 4;
  localparam int LINE_BYTES  = 32;
  localparam int ADDR_BITS   = 32;
  localparam int OFFSET_BITS = $clog2(LINE_BYTES);
  localparam int INDEX_BITS  = $clog2(SETS);
  localparam int TAG_BITS    = ADDR_BITS - OFFSET_BITS - INDEX_BITS;

  localparam int RANDOM_ITEMS = 1800;
  localparam int HOLD_START   = 3000;
  localparam int HOLD_CYCLES  = 300;
  localparam int CALM_START   = 6000;
  localparam int CALM_END     = 9000;
  localparam int DRAIN_LIMIT  = 20000;

  typedef struct packed {
    logic [31:0] address;
    logic [1:0]  victim;
    logic        typed;
    logic        hit;
    logic [1:0]  way;
    logic [31:0] hits;
    logic [31:0] misses;
  } access_row_t;

  localparam int DIRECTED_ROWS = 22;

  // Rows marked typed carry the result worked out by hand; the rest are
  // checked against the predictor alone.
  access_row_t directed_rows [DIRECTED_ROWS] = '{
    '{32'h0000_0000, 2'd0, 1'b1, 1'b0, 2'd0, 32'd0, 32'd1},
    '{32'h0000_001F, 2'd2, 1'b1, 1'b1, 2'd0, 32'd1, 32'd1},
    '{32'hFFFF_FFFF, 2'd3, 1'b1, 1'b0, 2'd3, 32'd1, 32'd2},
    '{32'hFFFF_FFE0, 2'd1, 1'b1, 1'b1, 2'd3, 32'd2, 32'd2},
    '{32'h0000_1000, 2'd1, 1'b1, 1'b0, 2'd1, 32'd2, 32'd3},
    '{32'h0000_2000, 2'd2, 1'b1, 1'b0, 2'd2, 32'd2, 32'd4},
    '{32'h0000_3000, 2'd3, 1'b1, 1'b0, 2'd3, 32'd2, 32'd5},
    '{32'h0000_3004, 2'd0, 1'b1, 1'b1, 2'd3, 32'd3, 32'd5},
    '{32'h0000_1010, 2'd0, 1'b1, 1'b1, 2'd1, 32'd4, 32'd5},
    '{32'h0000_0008, 2'd3, 1'b1, 1'b1, 2'd0, 32'd5, 32'd5},
    '{32'h0000_4000, 2'd2, 1'b1, 1'b0, 2'd2, 32'd5, 32'd6},
    '{32'h0000_2000, 2'd0, 1'b1, 1'b0, 2'd0, 32'd5, 32'd7},
    '{32'h0000_4000, 2'd1, 1'b1, 1'b1, 2'd2, 32'd6, 32'd7},
    '{32'h0000_0000, 2'd1, 1'b1, 1'b0, 2'd1, 32'd6, 32'd8},
    '{32'hFFFF_F000, 2'd0, 1'b1, 1'b0, 2'd0, 32'd6, 32'd9},
    '{32'h7FFF_FFE0, 2'd2, 1'b1, 1'b0, 2'd2, 32'd6, 32'd10},
    '{32'h8000_0FE0, 2'd0, 1'b1, 1'b0, 2'd0, 32'd6, 32'd11},
    '{32'hFFFF_FFC0, 2'd1, 1'b1, 1'b0, 2'd1, 32'd6, 32'd12},
    '{32'h7FFF_FFFF, 2'd3, 1'b1, 1'b1, 2'd2, 32'd7, 32'd12},
    '{32'hAAAA_AAAA, 2'd0, 1'b0, 1'b0, 2'd0, 32'd0, 32'd0},
    '{32'h5555_5555, 2'd3, 1'b0, 1'b0, 2'd0, 32'd0, 32'd0},
    '{32'hAAAA_AAAA, 2'd2, 1'b0, 1'b0, 2'd0, 32'd0, 32'd0}
  };

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  satl_pkg::satl_in_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  satl_pkg::satl_out_t out_data;

  // Predictor state.
  logic [TAG_BITS-1:0] tag_mem    [SETS][WAYS];
  bit                  line_valid [SETS][WAYS];
  logic [31:0]         hits_seen;
  logic [31:0]         misses_seen;

  satl_pkg::satl_out_t pending_lookups [$];
  int                  fault_count   = 0;
  int                  results_seen  = 0;
  bit                  sender_steady = 1'b0;

  set_assoc_cache_tag_lookup_core #(
    .SETS      (SETS),
    .WAYS      (WAYS),
    .LINE_BYTES(LINE_BYTES),
    .ADDR_BITS (ADDR_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [31:0] count_up(input logic [31:0] count);
    return (count == satl_pkg::CNT_MAX) ? count : count + 32'd1;
  endfunction

  function automatic satl_pkg::satl_out_t predict_lookup(input satl_pkg::satl_in_t item);
    logic [INDEX_BITS-1:0] set_idx;
    logic [TAG_BITS-1:0]   tag;
    logic [1:0]            fill_way;
    bit                    found;
    satl_pkg::satl_out_t   res;
    set_idx  = item.address[OFFSET_BITS +: INDEX_BITS];
    tag      = item.address[ADDR_BITS-1 -: TAG_BITS];
    fill_way = 2'(item.victim_way % WAYS);
    found    = 1'b0;
    res      = '0;
    // The lowest matching way wins; only valid entries are looked at.
    for (int w = 0; w < WAYS; w++) begin
      if (!found && line_valid[set_idx][w] && tag_mem[set_idx][w] == tag) begin
        found   = 1'b1;
        res.way = w[1:0];
      end
    end
    if (found) begin
      hits_seen = count_up(hits_seen);
    end else begin
      misses_seen                 = count_up(misses_seen);
      tag_mem[set_idx][fill_way]    = tag;
      line_valid[set_idx][fill_way] = 1'b1;
      res.way                     = fill_way;
    end
    res.hit        = found;
    res.hit_total  = hits_seen;
    res.miss_total = misses_seen;
    return res;
  endfunction

  // Mostly a small working set of sets and tags so that hits and evictions
  // are common; the rest is fully random addresses.
  function automatic satl_pkg::satl_in_t random_access();
    logic [TAG_BITS-1:0]   tag_pool [6];
    logic [INDEX_BITS-1:0] set_idx;
    satl_pkg::satl_in_t    item;
    tag_pool = '{20'h00000, 20'h00001, 20'h00002, 20'h00003, 20'hFFFFF, 20'h80000};
    item.victim_way = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 99) < 20) begin
      item.address = $urandom();
    end else begin
      if ($urandom_range(0, 9) == 0) begin
        set_idx = INDEX_BITS'($urandom_range(0, SETS - 1));
      end else begin
        set_idx = INDEX_BITS'($urandom_range(0, 15));
      end
      item.address = {tag_pool[$urandom_range(0, 5)], set_idx,
                      OFFSET_BITS'($urandom_range(0, LINE_BYTES - 1))};
    end
    return item;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    fault_count++;
    $display("mismatch in %s at result %0d: got %0h, expected %0h",
             field, results_seen, got, want);
  endtask

  // Offers one item, holds it until taken, then records what it should give.
  task automatic send_access(input satl_pkg::satl_in_t item, input bit typed,
                             input satl_pkg::satl_out_t typed_res);
    satl_pkg::satl_out_t predicted;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    predicted = predict_lookup(item);
    pending_lookups.push_back(typed ? typed_res : predicted);
    while (!sender_steady && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  initial begin
    satl_pkg::satl_out_t typed_res;
    satl_pkg::satl_in_t  item;
    int                  spins;
    for (int s = 0; s < SETS; s++) begin
      for (int w = 0; w < WAYS; w++) begin
        line_valid[s][w] = 1'b0;
        tag_mem[s][w]    = '0;
      end
    end
    hits_seen   = '0;
    misses_seen = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      item.address         = directed_rows[r].address;
      item.victim_way      = directed_rows[r].victim;
      typed_res.hit        = directed_rows[r].hit;
      typed_res.way        = directed_rows[r].way;
      typed_res.hit_total  = directed_rows[r].hits;
      typed_res.miss_total = directed_rows[r].misses;
      send_access(item, directed_rows[r].typed, typed_res);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sender_steady = (n >= 700 && n < 1100);
      send_access(random_access(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    spins = 0;
    while (pending_lookups.size() != 0 && spins < DRAIN_LIMIT) begin
      @(posedge clk);
      spins++;
    end
    if (pending_lookups.size() != 0) begin
      report_mismatch("results outstanding", pending_lookups.size(), 0);
    end
    repeat (20) @(posedge clk);

    if (fault_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold-off to back the block up, and a
  // stretch in which it always takes items.
  initial begin
    int rx_cycle;
    rx_cycle = 0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES) begin
        out_ready <= 1'b0;
      end else if (rx_cycle >= CALM_START && rx_cycle < CALM_END) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 25);
      end
    end
  end

  always @(posedge clk) begin
    satl_pkg::satl_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_lookups.size() == 0) begin
        report_mismatch("unexpected item", out_data.hit_total, 0);
      end else begin
        want = pending_lookups.pop_front();
        if (out_data.hit !== want.hit) begin
          report_mismatch("hit", 32'(out_data.hit), 32'(want.hit));
        end
        if (out_data.way !== want.way) begin
          report_mismatch("way", 32'(out_data.way), 32'(want.way));
        end
        if (out_data.hit_total !== want.hit_total) begin
          report_mismatch("hit_total", out_data.hit_total, want.hit_total);
        end
        if (out_data.miss_total !== want.miss_total) begin
          report_mismatch("miss_total", out_data.miss_total, want.miss_total);
        end
      end
      results_seen++;
    end
  end

endmodule
